FILE: rtl/core/msdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdd_pkg
// Types, constants and lookup functions for the segment display driver.
// ----------------------------------------------------------------------------
package msdd_pkg;

   localparam int GROUPS    = 8;
   localparam int DIGITS    = 4;
   localparam int BUF_DEPTH = GROUPS * DIGITS;
   localparam int GRP_W     = 3;
   localparam int POS_W     = 2;
   localparam int ADDR_W    = GRP_W + POS_W;
   localparam int VALUE_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // command codes
   localparam logic [1:0] CMD_NUMBER = 2'd0;
   localparam logic [1:0] CMD_LED    = 2'd1;
   localparam logic [1:0] CMD_SCAN   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LED_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_HIGH = 2'd1;

   localparam logic [GRP_W-1:0] LED_LOW_RESET  = 3'd6;
   localparam logic [GRP_W-1:0] LED_HIGH_RESET = 3'd7;

   // decimal conversion stages: 0 takes off tens of thousands, 4 stores ones
   localparam logic [2:0] STAGE_FIRST = 3'd0;
   localparam logic [2:0] STAGE_ONES  = 3'd4;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [GRP_W-1:0]   group;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             serial_bit;
      logic [POS_W-1:0] digit_select;
      logic             latch_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NUM,
      ST_LED,
      ST_SCAN_RD,
      ST_SCAN_LD,
      ST_SCAN_SH
   } state_type;

   // common-anode segment codes, active low
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'hc0;
         4'd1:    code = 8'hf9;
         4'd2:    code = 8'ha4;
         4'd3:    code = 8'hb0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hf8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hff;
      endcase
      return code;
   endfunction

   // weight subtracted at each conversion stage
   function automatic logic [VALUE_W-1:0] stage_weight(input logic [2:0] stage);
      logic [VALUE_W-1:0] w;
      case (stage)
         3'd0:    w = 16'd10000;
         3'd1:    w = 16'd1000;
         3'd2:    w = 16'd100;
         default: w = 16'd10;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/multiplexed_segment_display_driver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_segment_display_driver
// Segment buffer with decimal conversion, LED fill and serial scan-out.
// ----------------------------------------------------------------------------
// The block holds 8 groups of 4 digit bytes, all zero after reset, and takes
// one word at a time; req_ready is low until that word is finished. A number
// write reduces the value modulo 10000 and extracts its digits with one shared
// compare-subtract unit, at most one subtraction or one buffer write per
// cycle. An LED write fills the two LED groups through the single buffer
// write port. A scan tick fetches the first byte through the read and load
// states, then sends 64 response words from an 8-bit shift register, one
// serial bit per cycle while rsp_ready is high, group 0 first and msb first.
// The final word carries latch_last, after which the scanned digit advances
// modulo 4. Configuration writes are always taken (csr_ready is high).
module multiplexed_segment_display_driver (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  msdd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output msdd_pkg::rsp_type                rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [msdd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [msdd_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import msdd_pkg::*;

   state_type          state_ff, state_in;
   logic [GRP_W-1:0]   led_low_ff, led_low_in;
   logic [GRP_W-1:0]   led_high_ff, led_high_in;
   logic [POS_W-1:0]   digit_ff, digit_in;
   logic [VALUE_W-1:0] num_ff, num_in;
   logic [2:0]         stage_ff, stage_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [GRP_W-1:0]   tgt_grp_ff, tgt_grp_in;
   logic [2:0]         led_idx_ff, led_idx_in;
   logic [GRP_W-1:0]   scan_grp_ff, scan_grp_in;
   logic [2:0]         bit_ff, bit_in;
   logic [7:0]         shreg_ff, shreg_in;

   // segment buffer and its written flags
   logic [7:0]           buf_mem [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] buf_vld_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_vld_ff;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [7:0]         mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [GRP_W-1:0]   rd_grp;
   logic [GRP_W-1:0]   led_grp;

   // shared compare-subtract unit
   logic [VALUE_W:0]   diff;
   logic               borrow;

   assign diff   = {1'b0, num_ff} - {1'b0, stage_weight(stage_ff)};
   assign borrow = diff[VALUE_W];

   assign led_grp = led_idx_ff[2] ? led_high_ff : led_low_ff;

   // during shift-out, prefetch the next group's byte
   assign rd_grp    = (state_ff == ST_SCAN_SH) ? GRP_W'(scan_grp_ff + 1'b1) : scan_grp_ff;
   assign mem_raddr = {rd_grp, digit_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_SCAN_SH);

   always_comb begin
      rsp_data.serial_bit   = shreg_ff[7];
      rsp_data.digit_select = digit_ff;
      rsp_data.latch_last   = ({1'b0, scan_grp_ff} == 4'(GROUPS - 1)) && (bit_ff == 3'd7);
   end

   always_comb begin
      state_in    = state_ff;
      led_low_in  = led_low_ff;
      led_high_in = led_high_ff;
      digit_in    = digit_ff;
      num_in      = num_ff;
      stage_in    = stage_ff;
      cnt_in      = cnt_ff;
      tgt_grp_in  = tgt_grp_ff;
      led_idx_in  = led_idx_ff;
      scan_grp_in = scan_grp_ff;
      bit_in      = bit_ff;
      shreg_in    = shreg_ff;
      mem_we      = 1'b0;
      mem_waddr   = {tgt_grp_ff, POS_W'(0)};
      mem_wdata   = seg_code(cnt_ff);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LED_LOW:  led_low_in  = csr_wdata[GRP_W-1:0];
            CSR_LED_HIGH: led_high_in = csr_wdata[GRP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in      = req_data.value;
               tgt_grp_in  = req_data.group;
               stage_in    = STAGE_FIRST;
               cnt_in      = 4'd0;
               led_idx_in  = 3'd0;
               scan_grp_in = '0;
               unique case (req_data.cmd)
                  CMD_NUMBER: begin
                     if ({1'b0, req_data.group} < 4'(GROUPS)) begin
                        state_in = ST_NUM;
                     end
                  end
                  CMD_LED:  state_in = ST_LED;
                  CMD_SCAN: state_in = ST_SCAN_RD;
                  default: ;
               endcase
            end
         end
         ST_NUM: begin
            if (stage_ff == STAGE_ONES) begin
               mem_we    = 1'b1;
               mem_waddr = {tgt_grp_ff, POS_W'(0)};
               mem_wdata = seg_code(num_ff[3:0]);
               state_in  = ST_IDLE;
            end else if (!borrow) begin
               num_in = diff[VALUE_W-1:0];
               if (stage_ff != STAGE_FIRST) begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end else begin
               stage_in = stage_ff + 3'd1;
               cnt_in   = 4'd0;
               if (stage_ff != STAGE_FIRST) begin
                  // thousands land in position 3, tens in position 1
                  mem_we    = 1'b1;
                  mem_waddr = {tgt_grp_ff, POS_W'(STAGE_ONES - stage_ff)};
                  mem_wdata = seg_code(cnt_ff);
               end
            end
         end
         ST_LED: begin
            mem_we     = ({1'b0, led_grp} < 4'(GROUPS));
            mem_waddr  = {led_grp, led_idx_ff[1:0]};
            mem_wdata  = led_idx_ff[2] ? num_ff[15:8] : num_ff[7:0];
            led_idx_in = led_idx_ff + 3'd1;
            if (led_idx_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_LD;
         end
         ST_SCAN_LD: begin
            shreg_in = rd_vld_ff ? rd_data_ff : 8'h00;
            bit_in   = 3'd0;
            state_in = ST_SCAN_SH;
         end
         ST_SCAN_SH: begin
            if (rsp_ready) begin
               bit_in = bit_ff + 3'd1;
               if (bit_ff == 3'd7) begin
                  if (rsp_data.latch_last) begin
                     digit_in = digit_ff + POS_W'(1);
                     state_in = ST_IDLE;
                  end else begin
                     scan_grp_in = scan_grp_ff + GRP_W'(1);
                     shreg_in    = rd_vld_ff ? rd_data_ff : 8'h00;
                  end
               end else begin
                  shreg_in = {shreg_ff[6:0], 1'b0};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         led_low_ff  <= LED_LOW_RESET;
         led_high_ff <= LED_HIGH_RESET;
         digit_ff    <= '0;
         buf_vld_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         led_low_ff  <= led_low_in;
         led_high_ff <= led_high_in;
         digit_ff    <= digit_in;
         if (mem_we) begin
            buf_vld_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      stage_ff    <= stage_in;
      cnt_ff      <= cnt_in;
      tgt_grp_ff  <= tgt_grp_in;
      led_idx_ff  <= led_idx_in;
      scan_grp_ff <= scan_grp_in;
      bit_ff      <= bit_in;
      shreg_ff    <= shreg_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= buf_mem[mem_raddr];
      rd_vld_ff  <= buf_vld_ff[mem_raddr];
   end

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the segment display driver. A scoreboard tracks the segment
// buffer, the scan digit and both LED group registers. Every scan tick
// queues its 64 serial words. Each returned word is compared against the
// head of that queue. Directed corner cases come first, then random traffic
// over several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import msdd_pkg::*;

   localparam logic [1:0]           CMD_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int SETTLE_CYCLES = 48;   // longest number write plus margin
   localparam int PHASES        = 6;
   localparam int PHASE_WORDS   = 65;

   logic clock;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // scoreboard state
   logic [7:0]       segment_buf [BUF_DEPTH];
   logic [POS_W-1:0] scan_pos;
   logic [GRP_W-1:0] led_low_grp;
   logic [GRP_W-1:0] led_high_grp;
   rsp_type          scan_bits [$];
   logic [7:0]       digit_font [10] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99,
                                         8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};

   int mismatches = 0;
   bit calm = 1'b0;

   multiplexed_segment_display_driver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("[multiplexed_segment_display_driver] ERROR");
      $finish;
   end

   // update the scoreboard for one accepted word
   task automatic predict_word(input req_type w);
      int unsigned num;
      logic [7:0]  cur;
      rsp_type     sb;
      case (w.cmd)
         CMD_NUMBER: begin
            num = w.value % 10000;
            for (int i = 0; i < DIGITS; i++) begin
               segment_buf[w.group * DIGITS + i] = digit_font[num % 10];
               num = num / 10;
            end
         end
         CMD_LED: begin
            // high byte goes second so it wins when both name one group
            for (int i = 0; i < DIGITS; i++) begin
               segment_buf[led_low_grp * DIGITS + i]  = w.value[7:0];
               segment_buf[led_high_grp * DIGITS + i] = w.value[15:8];
            end
         end
         CMD_SCAN: begin
            for (int g = 0; g < GROUPS; g++) begin
               cur = segment_buf[g * DIGITS + scan_pos];
               for (int b = 7; b >= 0; b--) begin
                  sb.serial_bit   = cur[b];
                  sb.digit_select = scan_pos;
                  sb.latch_last   = (g == GROUPS - 1) && (b == 0);
                  scan_bits.push_back(sb);
               end
            end
            scan_pos = scan_pos + 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic send_word(input logic [1:0] cmd, input logic [GRP_W-1:0] grp,
                            input logic [VALUE_W-1:0] val);
      req_type w;
      w.cmd   = cmd;
      w.group = grp;
      w.value = val;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(w);
   endtask

   // pause the sender until every queued word has come back and the block is idle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scan_bits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_LED_LOW:  led_low_grp  = data[GRP_W-1:0];
         CSR_LED_HIGH: led_high_grp = data[GRP_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic report_bad(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected bit %b digit %0d latch %b, got bit %b digit %0d latch %b",
                  $realtime, what, want.serial_bit, want.digit_select, want.latch_last,
                  got.serial_bit, got.digit_select, got.latch_last);
   endtask

   always @(posedge clock) begin : check_scan_out
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scan_bits.size() == 0) begin
            report_bad("unexpected word", '0, rsp_data);
         end else begin
            want = scan_bits.pop_front();
            if (rsp_data.serial_bit !== want.serial_bit ||
                rsp_data.digit_select !== want.digit_select ||
                rsp_data.latch_last !== want.latch_last)
               report_bad("wrong word", want, rsp_data);
         end
      end
   end

   // receiver stalls in random bursts
   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // all zero buffer, digit wraps through all four positions
   task automatic test_reset_state();
      repeat (4) send_word(CMD_SCAN, 3'd0, 16'h0000);
   endtask

   task automatic test_number_extremes();
      send_word(CMD_NUMBER, 3'd0, 16'd0);
      send_word(CMD_NUMBER, 3'd7, 16'd9999);
      send_word(CMD_NUMBER, 3'd1, 16'd10000);
      send_word(CMD_NUMBER, 3'd2, 16'hffff);
      send_word(CMD_NUMBER, 3'd3, 16'd1234);
      repeat (4) send_word(CMD_SCAN, 3'd7, 16'hffff);
   endtask

   // default groups 6 and 7
   task automatic test_led_write();
      send_word(CMD_LED, 3'd5, 16'hff00);
      send_word(CMD_SCAN, 3'd0, 16'h0000);
      send_word(CMD_LED, 3'd2, 16'h5aa5);
      send_word(CMD_SCAN, 3'd0, 16'h0000);
   endtask

   task automatic test_unused_command();
      send_word(CMD_SPARE, 3'd7, 16'hffff);
      send_word(CMD_SPARE, 3'd0, 16'h0000);
      send_word(CMD_SCAN, 3'd0, 16'h0000);
   endtask

   // both LED groups equal, masked data, writes to unused indexes
   task automatic test_register_corners();
      wait_drained();
      write_csr(CSR_LED_LOW, 8'hfd);
      write_csr(CSR_LED_HIGH, 8'h05);
      write_csr(CSR_SPARE_A, 8'h00);
      write_csr(CSR_SPARE_B, 8'h01);
      send_word(CMD_LED, 3'd0, 16'h1234);
      send_word(CMD_SCAN, 3'd0, 16'h0000);
   endtask

   task automatic test_random_traffic();
      logic [GRP_W-1:0]   lo;
      logic [GRP_W-1:0]   hi;
      logic [4:0]         junk;
      logic [7:0]         spare;
      logic [VALUE_W-1:0] val;
      int                 sent;
      int                 pick;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin lo = 3'd0; hi = 3'd7; end
            1: begin lo = 3'd7; hi = 3'd0; end
            2: begin lo = 3'd3; hi = 3'd3; end
            default: begin
               lo = GRP_W'($urandom_range(0, 7));
               hi = GRP_W'($urandom_range(0, 7));
            end
         endcase
         junk = 5'($urandom);
         write_csr(CSR_LED_LOW, {junk, lo});
         junk = 5'($urandom);
         write_csr(CSR_LED_HIGH, {junk, hi});
         spare = 8'($urandom);
         write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, spare);
         calm = (phase == PHASES - 1);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            val  = VALUE_W'($urandom);
            if (pick < 8) begin
               send_word(CMD_SPARE, GRP_W'($urandom_range(0, 7)), val);
            end else if (pick < 45) begin
               send_word(CMD_SCAN, GRP_W'($urandom_range(0, 7)), val);
               sent++;
            end else if (pick < 80) begin
               case ($urandom_range(0, 3))
                  0: ;
                  1: val = VALUE_W'($urandom_range(0, 9999));
                  2: val = VALUE_W'($urandom_range(9990, 10010));
                  default: val = VALUE_W'($urandom_range(60000, 65535));
               endcase
               send_word(CMD_NUMBER, GRP_W'($urandom_range(0, 7)), val);
               sent++;
            end else begin
               send_word(CMD_LED, GRP_W'($urandom_range(0, 7)), val);
               sent++;
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < BUF_DEPTH; i++) segment_buf[i] = 8'h00;
      scan_pos     = '0;
      led_low_grp  = LED_LOW_RESET;
      led_high_grp = LED_HIGH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_number_extremes();
      test_led_write();
      test_unused_command();
      test_register_corners();
      test_random_traffic();
      wait_drained();
      if (mismatches == 0 && scan_bits.size() == 0)
         $display("[multiplexed_segment_display_driver] OK");
      else
         $display("[multiplexed_segment_display_driver] ERROR");
      $finish;
   end

endmodule
